[rtl/ebpp_pkg.sv]
// Shared types and constants for the EEG band-power packet parser.
// No dependencies; every other file of the block depends on this package.
package ebpp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] LEN_REJECT  = 8'd4;
  localparam int         PAYLOAD_LEN = 28;
  localparam int         BAND_COUNT  = 8;
  localparam int         BAND_FIRST  = 4;   // payload index of the first band MSB
  localparam int         BAND_BYTES  = 3;
  localparam int         ADDR_W      = $clog2(PAYLOAD_LEN);
  localparam int         COUNT_W     = $clog2(PAYLOAD_LEN + 1);
  localparam int         BAND_W      = 8 * BAND_BYTES;

  typedef enum logic [1:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN,
    PH_DATA
  } phase_t;

  // Control from the framing FSM to the payload store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              done;     // packet end: result is formed this beat
  } ctrl_t;

  typedef struct packed {
    logic [7:0]                       quality;
    logic [BAND_COUNT-1:0][BAND_W-1:0] band;   // band[0] = delta ... band[7] = mid gamma
  } result_t;

endpackage

[rtl/ebpp_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on ebpp_pkg for field widths.
interface ebpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ebpp_result_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 quality;
  logic [ebpp_pkg::BAND_W-1:0] delta_power;
  logic [ebpp_pkg::BAND_W-1:0] theta_power;
  logic [ebpp_pkg::BAND_W-1:0] low_alpha_power;
  logic [ebpp_pkg::BAND_W-1:0] high_alpha_power;
  logic [ebpp_pkg::BAND_W-1:0] low_beta_power;
  logic [ebpp_pkg::BAND_W-1:0] high_beta_power;
  logic [ebpp_pkg::BAND_W-1:0] low_gamma_power;
  logic [ebpp_pkg::BAND_W-1:0] mid_gamma_power;

  modport source (output valid, output quality, output delta_power, output theta_power,
                  output low_alpha_power, output high_alpha_power, output low_beta_power,
                  output high_beta_power, output low_gamma_power, output mid_gamma_power,
                  input ready);
  modport sink   (input valid, input quality, input delta_power, input theta_power,
                  input low_alpha_power, input high_alpha_power, input low_beta_power,
                  input high_beta_power, input low_gamma_power, input mid_gamma_power,
                  output ready);
endinterface

[rtl/ebpp_ctrl.sv]
// Framing FSM: sync hunt, length check and payload byte counting.
// Depends on ebpp_pkg.
module ebpp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  output ebpp_pkg::ctrl_t   ctrl
);
  import ebpp_pkg::*;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               full;
  logic               len_ok;

  assign full   = (count == COUNT_W'(PAYLOAD_LEN));
  assign len_ok = (rx_byte < SYNC_BYTE) && (rx_byte != LEN_REJECT);

  always_comb begin
    phase_next = phase;
    if (beat) begin
      unique case (phase)
        PH_SYNC1: phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        PH_SYNC2: phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        PH_LEN:   phase_next = len_ok ? PH_DATA : PH_SYNC1;
        PH_DATA:  phase_next = full ? PH_SYNC1 : PH_DATA;
        default:  phase_next = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    count_next   = count;
    ctrl.wr_en   = 1'b0;
    ctrl.done    = 1'b0;
    ctrl.wr_addr = count[ADDR_W-1:0];
    if (beat) begin
      unique case (phase)
        PH_LEN: begin
          if (len_ok) count_next = '0;
        end
        PH_DATA: begin
          if (full) begin
            ctrl.done = 1'b1;
          end else begin
            ctrl.wr_en = 1'b1;
            count_next = count + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(PAYLOAD_LEN))
    else $error("payload count overran");
  a_done_exits: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |=> phase == PH_SYNC1)
    else $error("packet end did not return to sync hunt");
  a_len_clears: assert property (@(posedge clk) disable iff (rst)
    beat && phase == PH_LEN && len_ok |=> phase == PH_DATA && count == '0)
    else $error("accepted length did not start a fresh capture");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr_en && ctrl.done))
    else $error("store write and packet end in one beat");
`endif

endmodule

[rtl/ebpp_store.sv]
// Payload byte store (28 x 8) and result assembly from its fixed positions.
// Depends on ebpp_pkg.
module ebpp_store (
  input  logic              clk,
  input  logic [7:0]        rx_byte,
  input  ebpp_pkg::ctrl_t   ctrl,
  output ebpp_pkg::result_t result
);
  import ebpp_pkg::*;

  localparam int BAND_IDX_W = $clog2(BAND_COUNT);

  logic [7:0] mem [PAYLOAD_LEN];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) mem[ctrl.wr_addr] <= rx_byte;
  end

  // bytes 1..3 are held but never reported
  always_comb begin
    result.quality = mem[ADDR_W'(0)];
    for (int k = 0; k < BAND_COUNT; k++) begin
      result.band[BAND_IDX_W'(k)] = {mem[ADDR_W'(BAND_FIRST + BAND_BYTES*k)],
                                     mem[ADDR_W'(BAND_FIRST + BAND_BYTES*k + 1)],
                                     mem[ADDR_W'(BAND_FIRST + BAND_BYTES*k + 2)]};
    end
  end

endmodule

[rtl/eeg_band_packet_parser.sv]
// EEG band-power packet parser, top level: FSM, payload store, result register.
// Depends on ebpp_pkg, ebpp_if, ebpp_ctrl and ebpp_store.
//
// Takes one serial byte per beat on byte_in and frames packets of the form
// 0xAA 0xAA <len> <28 payload bytes> <trailing byte>. A length byte of 4 or
// of 0xAA and above aborts the packet and hunting restarts. The checksum is
// not checked. The byte after the 28th payload byte is dropped and produces
// one result beat on result_out: quality (payload byte 0) and eight 24-bit
// big-endian band powers from payload bytes 4..27. Every other byte produces
// nothing. Throughput is one byte per clock: each byte costs a compare and a
// register write, and the result leaves through a single output register, so
// byte_in stays ready while result_out is empty or being taken. A pending
// result that is not taken stalls byte_in until it is. The result beat appears
// in the cycle after the trailing byte is taken. No clearing pass after reset.
module eeg_band_packet_parser (
  input  logic              clk,
  input  logic              rst,
  ebpp_byte_if.sink         byte_in,
  ebpp_result_if.source     result_out
);
  import ebpp_pkg::*;

  ctrl_t   ctrl;
  result_t result;      // combinational view of the store
  result_t result_q;    // output register
  logic    out_valid;
  logic    beat;
  logic    slot_free;

  // output slot frees when empty or its beat is taken this cycle
  assign slot_free     = !out_valid || result_out.ready;
  assign byte_in.ready = slot_free;
  assign beat          = byte_in.valid && slot_free;

  ebpp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .rx_byte (byte_in.rx_byte),
    .ctrl    (ctrl)
  );

  ebpp_store u_store (
    .clk     (clk),
    .rx_byte (byte_in.rx_byte),
    .ctrl    (ctrl),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= ctrl.done;
    end
  end

  // payload needs no reset; loaded only on packet end
  always_ff @(posedge clk) begin
    if (ctrl.done) result_q <= result;
  end

  assign result_out.valid            = out_valid;
  assign result_out.quality          = result_q.quality;
  assign result_out.delta_power      = result_q.band[0];
  assign result_out.theta_power      = result_q.band[1];
  assign result_out.low_alpha_power  = result_q.band[2];
  assign result_out.high_alpha_power = result_q.band[3];
  assign result_out.low_beta_power   = result_q.band[4];
  assign result_out.high_beta_power  = result_q.band[5];
  assign result_out.low_gamma_power  = result_q.band[6];
  assign result_out.mid_gamma_power  = result_q.band[7];

`ifndef ASSERT_OFF
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.done))
    else $error("result beat appeared without a packet end");
  a_no_lost: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |-> slot_free)
    else $error("packet end while output slot occupied");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |=> $stable(result_q))
    else $error("pending result overwritten");
`endif

endmodule
